/* sv/lev_pkg.sv */
`timescale 1ns / 1ps

package lev_pkg;

  // Sizing of the pattern store and the distance arithmetic.
  localparam int MAX_PATTERN = 32;
  localparam int DIST_WIDTH  = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CH_W        = 8;
  localparam int OUT_W       = 16;

  typedef logic [DIST_WIDTH-1:0] dist_t;
  localparam dist_t DIST_MAX = '1;

  // Operation codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_END    = 2'd3
  } func_t;

  typedef struct packed {
    func_t           func;
    logic [CH_W-1:0] ch;
  } lev_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] distance;
    logic             pattern_overflow;
  } lev_out_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             reload;
    logic             wr_en;
    logic [LEN_W-1:0] len;
    logic [CH_W-1:0]  wr_ch;
  } lev_ctl_t;

  // Wavefront handed from one cell to the next.
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
    dist_t           prev;
    dist_t           diag;
  } lev_wave_t;

  // Add one, holding at the top of the range.
  function automatic dist_t sat_inc1(dist_t v);
    return (v == DIST_MAX) ? v : v + dist_t'(1);
  endfunction

  // Column value after a reload: index plus one, saturated.
  function automatic dist_t reload_val(logic [IDX_W-1:0] idx);
    logic [32:0] v;
    v = 33'(idx) + 33'd1;
    return (v > 33'(DIST_MAX)) ? DIST_MAX : v[DIST_WIDTH-1:0];
  endfunction

  // Clamp a distance to the width of the result field.
  function automatic logic [OUT_W-1:0] to_out(dist_t d);
    logic [32:0] e;
    e = 33'(d);
    return (e > 33'h0_0000_FFFF) ? '1 : e[OUT_W-1:0];
  endfunction

endpackage

/* sv/levenshtein_edit_distance_unit.sv */
`timescale 1ns / 1ps

// Levenshtein edit distance between a stored pattern and a streamed text.
// The input channel (in_valid/in_ready/in_data) carries one operation per
// transaction: clear the pattern, append a pattern byte, apply a text byte,
// or end the text. Only the end-of-text transaction yields a result on the
// output channel (out_valid/out_ready/out_data), with the distance and the
// pattern overflow flag.
// Text bytes enter a row of cells, one per pattern position, and are taken
// one per cycle; each cell registers a byte before it passes it on. Clear,
// append and end-of-text wait until the last text byte has left the row,
// and an end of text that is taken shows its result in out_data on the
// following cycle.
// The result sits in an output register; while the receiver stalls, text
// bytes, clears and appends are still taken, and only the next end-of-text
// waits for the register to empty.
// Reset empties the pattern, clears the overflow flag and the text count,
// and loads the distance column with its initial values.
module levenshtein_edit_distance_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lev_pkg::lev_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lev_pkg::lev_out_t out_data
);
  import lev_pkg::*;

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  dist_t            tc_r;
  dist_t            tc_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  lev_out_t         out_data_r;
  lev_out_t         out_data_nxt;

  logic             in_acc;
  logic             busy;
  logic             full;
  lev_ctl_t         ctl;
  lev_wave_t        wave_in;
  dist_t            dist_vec [MAX_PATTERN];
  logic [LEN_W-1:0] last_pos;
  dist_t            result;

  assign full   = (len_r == LEN_W'(MAX_PATTERN));
  assign in_acc = in_valid && in_ready;

  // Text streams freely; others need an idle row, end also a free output.
  always_comb begin
    unique case (in_data.func)
      FUNC_TEXT:   in_ready = 1'b1;
      FUNC_END:    in_ready = !busy && (!out_valid_r || out_ready);
      default:     in_ready = !busy;
    endcase
  end

  // Broadcast control and the head of the wavefront.
  always_comb begin
    ctl.reload   = in_acc && (in_data.func != FUNC_TEXT);
    ctl.wr_en    = in_acc && (in_data.func == FUNC_APPEND) && !full;
    ctl.len      = len_r;
    ctl.wr_ch    = in_data.ch;
    wave_in.valid = in_acc && (in_data.func == FUNC_TEXT);
    wave_in.ch    = in_data.ch;
    wave_in.prev  = sat_inc1(tc_r);
    wave_in.diag  = tc_r;
  end

  lev_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .wave_i (wave_in),
    .dist_o (dist_vec),
    .busy_o (busy)
  );

  // Distance of the full pattern, or the text count for an empty pattern.
  assign last_pos = len_r - LEN_W'(1);
  assign result   = (len_r == '0) ? tc_r : dist_vec[last_pos[IDX_W-1:0]];

  // Pattern length, overflow flag and text count.
  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    tc_nxt  = tc_r;
    if (in_acc) begin
      case (in_data.func)
        FUNC_CLEAR: begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
          tc_nxt  = '0;
        end
        FUNC_APPEND: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt = len_r + LEN_W'(1);
          end
          tc_nxt = '0;
        end
        FUNC_TEXT: tc_nxt = sat_inc1(tc_r);
        default:   tc_nxt = '0;
      endcase
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (in_acc && (in_data.func == FUNC_END)) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.distance         = to_out(result);
      out_data_nxt.pattern_overflow = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      tc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      tc_r        <= tc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/lev_cell.sv */
`timescale 1ns / 1ps

module lev_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [lev_pkg::IDX_W-1:0] idx,
  input  lev_pkg::lev_ctl_t        ctl,
  input  lev_pkg::lev_wave_t       wave_i,
  output lev_pkg::lev_wave_t       wave_o,
  output lev_pkg::dist_t           dist_o
);
  import lev_pkg::*;

  logic [CH_W-1:0] pat_r;
  dist_t           dist_r;
  dist_t           dist_nxt;
  lev_wave_t       wave_r;
  lev_wave_t       wave_nxt;
  logic            active;
  dist_t           min_ab;
  dist_t           up_cost;
  dist_t           diag_cost;
  dist_t           cell_new;

  // A cell takes part only while it lies inside the stored pattern.
  assign active = LEN_W'(idx) < ctl.len;

  // One table entry: min of deletion, insertion and substitution paths.
  always_comb begin
    min_ab    = (dist_r < wave_i.prev) ? dist_r : wave_i.prev;
    up_cost   = sat_inc1(min_ab);
    diag_cost = (pat_r == wave_i.ch) ? wave_i.diag : sat_inc1(wave_i.diag);
    cell_new  = (up_cost < diag_cost) ? up_cost : diag_cost;
  end

  always_comb begin
    dist_nxt = dist_r;
    wave_nxt = '0;
    if (ctl.reload) begin
      dist_nxt = reload_val(idx);
    end else if (wave_i.valid && active) begin
      dist_nxt       = cell_new;
      wave_nxt.valid = 1'b1;
      wave_nxt.ch    = wave_i.ch;
      wave_nxt.prev  = cell_new;
      wave_nxt.diag  = dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= reload_val(idx);
      wave_r <= '0;
    end else begin
      dist_r <= dist_nxt;
      wave_r <= wave_nxt;
    end
  end

  // The pattern byte is written when the append lands on this position.
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.len == LEN_W'(idx))) begin
      pat_r <= ctl.wr_ch;
    end
  end

  assign wave_o = wave_r;
  assign dist_o = dist_r;

endmodule

/* sv/lev_chain.sv */
`timescale 1ns / 1ps

module lev_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  lev_pkg::lev_ctl_t  ctl,
  input  lev_pkg::lev_wave_t wave_i,
  output lev_pkg::dist_t     dist_o [lev_pkg::MAX_PATTERN],
  output logic               busy_o
);
  import lev_pkg::*;

  lev_wave_t wave [MAX_PATTERN+1];

  assign wave[0] = wave_i;

  // Row of cells; each text byte walks one cell per cycle.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    lev_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .idx    (IDX_W'(i)),
      .ctl    (ctl),
      .wave_i (wave[i]),
      .wave_o (wave[i+1]),
      .dist_o (dist_o[i])
    );
  end

  // The row is busy while any wavefront is still between cells.
  always_comb begin
    busy_o = 1'b0;
    for (int i = 1; i <= MAX_PATTERN; i++) begin
      busy_o = busy_o | wave[i].valid;
    end
  end

endmodule

/* sv/lev_checker.sv */
`timescale 1ns / 1ps

module lev_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input lev_pkg::lev_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input lev_pkg::lev_out_t out_data
);
  import lev_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A new result appears only after an end-of-text transaction.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_data.func == FUNC_END)))
    else $error("result without end-of-text");

  // End of text is never taken while a stalled result would be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == FUNC_END) |-> !out_valid || out_ready)
    else $error("end-of-text taken over a pending result");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind levenshtein_edit_distance_unit lev_checker u_lev_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
